>>> design/cascaded_position_speed_pid_top_defines.svh
// assertion macros used by the checker file
`ifndef CASCADED_POSITION_SPEED_PID_TOP_DEFINES_SVH
`define CASCADED_POSITION_SPEED_PID_TOP_DEFINES_SVH

// condition now implies consequence in the next cycle
`define CPSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsp assertion failed");

// condition now implies consequence in the same cycle
`define CPSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsp assertion failed");

`endif

>>> design/cpsp_pkg.sv
package cpsp_pkg;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         joint;
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_speed;
        logic signed [31:0] set_value;
    } in_item_t;

    typedef struct packed {
        logic [30:0]        duty_magnitude;
        logic               direction_forward;
        logic signed [31:0] drive_signed;
        logic signed [31:0] speed_command;
    } out_item_t;

    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_SET_ANGLE  = 2'd1;
    localparam logic [1:0] REQ_SET_SPEED  = 2'd2;
    localparam logic [1:0] REQ_SET_ENGAGE = 2'd3;

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_KP      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_KI      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_KD      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPD_KP      = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPD_KI      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPD_KD      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DC_BIAS     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT = 4'd7;

    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_ERR   = 4'd1;
    localparam logic [3:0] OP_DERR  = 4'd2;
    localparam logic [3:0] OP_MUL_P = 4'd3;
    localparam logic [3:0] OP_MUL_I = 4'd4;
    localparam logic [3:0] OP_MUL_D = 4'd5;
    localparam logic [3:0] OP_SUM   = 4'd6;
    localparam logic [3:0] OP_WB    = 4'd7;
    localparam logic [3:0] OP_BIAS  = 4'd8;
    localparam logic [3:0] OP_SET   = 4'd9;
    localparam logic [3:0] OP_OUT   = 4'd10;

    // engaged joints after reset: 0 1 2 4
    localparam logic [15:0] ENGAGE_RESET = 16'h0017;

    typedef struct packed {
        logic       capture;
        logic [3:0] op;
        logic       loop_pos;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       joint_ok;
        logic       engaged;
        logic       out_busy;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clampv(input logic signed [33:0] v,
                                                  input logic [31:0] lim);
        logic signed [33:0] l;
        logic signed [33:0] r;
        l = $signed({2'b00, lim});
        if (v > l)
            r = l;
        else if (v < -l)
            r = -l;
        else
            r = v;
        return r[31:0];
    endfunction

    // q16.16 product: floor shift by 16 then saturate
    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic signed [31:0] r;
        if ((&p[63:47]) || !(|p[63:47]))
            r = p[47:16];
        else if (p[63])
            r = 32'sh80000000;
        else
            r = 32'sh7FFFFFFF;
        return r;
    endfunction

endpackage

>>> design/cascaded_position_speed_pid_top.sv
// cascaded position and speed pid for a set of joints, q16.16 fixed point
// input channel in_valid / in_stall carries one request transaction: a
//   control tick with measured angle and speed, or a set of angle target,
//   speed target or engage flag for one joint
// output channel out_valid / out_stall returns one result transaction per
//   request: duty magnitude, held direction, signed drive, speed target
// config channel cfg_valid / cfg_ready writes gains, bias and speed limit;
//   cfg_ready is always high, write only while no request is in flight
// one request at a time; each pid pass is a fixed sequence of seven steps
//   through one shared 32x32 multiplier; an engaged tick runs the position
//   pass then the speed pass, a disengaged tick only the speed pass
// in_stall is high from accept until the result is loaded into the output
//   register; a waiting result blocks the next accept, since its loading
//   waits while out_stall holds the previous result
// reset: per joint targets, integrals and last errors clear, joints 0 1 2 4
//   are engaged, direction bits clear, gains and bias clear, speed limit max
module cascaded_position_speed_pid_top
    import cpsp_pkg::*;
#(
    parameter int JOINTS               = 6,
    parameter int ANGLE_LIMIT          = 11796480,
    parameter int POS_INTEGRAL_LIMIT   = 6553600,
    parameter int SPEED_INTEGRAL_LIMIT = 6553600,
    parameter int DUTY_LIMIT           = 6553600
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // register writes never wait
    assign cfg_ready = 1'b1;

    // sequencer: steps the shared datapath through each pid pass
    cpsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // joint state, config registers, multiplier and output register
    cpsp_datapath
    #(
        .JOINTS               (JOINTS),
        .ANGLE_LIMIT          (ANGLE_LIMIT),
        .POS_INTEGRAL_LIMIT   (POS_INTEGRAL_LIMIT),
        .SPEED_INTEGRAL_LIMIT (SPEED_INTEGRAL_LIMIT),
        .DUTY_LIMIT           (DUTY_LIMIT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> design/cpsp_ctrl.sv
module cpsp_ctrl
    import cpsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_ERR  = 4'd2;
    localparam logic [3:0] S_DERR = 4'd3;
    localparam logic [3:0] S_MP   = 4'd4;
    localparam logic [3:0] S_MI   = 4'd5;
    localparam logic [3:0] S_MD   = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_BIAS = 4'd9;
    localparam logic [3:0] S_SET  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       pos_reg, pos_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        cmd.loop_pos = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!status.joint_ok)
                    state_next = S_OUT;
                else if (status.req_type != REQ_TICK)
                    state_next = S_SET;
                else
                begin
                    pos_next   = status.engaged;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_DERR;
            end
            S_DERR:
            begin
                cmd.op     = OP_DERR;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd.op     = OP_MUL_P;
                state_next = S_MI;
            end
            S_MI:
            begin
                cmd.op     = OP_MUL_I;
                state_next = S_MD;
            end
            S_MD:
            begin
                cmd.op     = OP_MUL_D;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op = OP_WB;
                if (pos_reg)
                begin
                    pos_next   = 1'b0;
                    state_next = S_ERR;
                end
                else
                    state_next = S_BIAS;
            end
            S_BIAS:
            begin
                cmd.op     = OP_BIAS;
                state_next = S_OUT;
            end
            S_SET:
            begin
                cmd.op     = OP_SET;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

>>> design/cpsp_datapath.sv
module cpsp_datapath
    import cpsp_pkg::*;
#(
    parameter int JOINTS               = 6,
    parameter int ANGLE_LIMIT          = 11796480,
    parameter int POS_INTEGRAL_LIMIT   = 6553600,
    parameter int SPEED_INTEGRAL_LIMIT = 6553600,
    parameter int DUTY_LIMIT           = 6553600
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  in_item_t               in_data,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic [31:0] ANG_L  = 32'(ANGLE_LIMIT);
    localparam logic [31:0] PI_L   = 32'(POS_INTEGRAL_LIMIT);
    localparam logic [31:0] SI_L   = 32'(SPEED_INTEGRAL_LIMIT);
    localparam logic [31:0] DUTY_L = 32'(DUTY_LIMIT);

    in_item_t           item_reg;
    logic signed [31:0] pos_kp_reg, pos_ki_reg, pos_kd_reg;
    logic signed [31:0] spd_kp_reg, spd_ki_reg, spd_kd_reg;
    logic [30:0]        dc_bias_reg, scl_reg;

    logic signed [31:0] at_reg [JOINTS];
    logic signed [31:0] pi_reg [JOINTS];
    logic signed [31:0] pl_reg [JOINTS];
    logic signed [31:0] st_reg [JOINTS];
    logic signed [31:0] si_reg [JOINTS];
    logic signed [31:0] sl_reg [JOINTS];
    logic [JOINTS-1:0]  engaged_reg, dir_reg;

    logic signed [31:0] e_reg, de_reg, p_reg, i_reg, d_reg, o_reg, drive_reg;
    // p + i kept unsaturated so only the full three term sum saturates
    logic signed [33:0] s_reg;
    logic signed [63:0] prod_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [JW-1:0]      jidx;
    logic               joint_ok;
    logic signed [31:0] tgt, meas, last, integ, kp, ki, kd, ma, mb;
    logic [31:0]        ilim;
    logic signed [31:0] err_c, de_c, i_c, o_c, drive_c, neg_drive;
    logic signed [63:0] prod_c;
    logic signed [33:0] bias34, o2, sum_c;

    assign jidx     = JW'(item_reg.joint);
    assign joint_ok = ({2'b00, item_reg.joint} < 5'(JOINTS));

    assign status.req_type = item_reg.req_type;
    assign status.joint_ok = joint_ok;
    assign status.engaged  = engaged_reg[jidx];
    assign status.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        tgt   = cmd.loop_pos ? at_reg[jidx] : st_reg[jidx];
        meas  = cmd.loop_pos ? item_reg.measured_angle : item_reg.measured_speed;
        last  = cmd.loop_pos ? pl_reg[jidx] : sl_reg[jidx];
        integ = cmd.loop_pos ? pi_reg[jidx] : si_reg[jidx];
        kp    = cmd.loop_pos ? pos_kp_reg : spd_kp_reg;
        ki    = cmd.loop_pos ? pos_ki_reg : spd_ki_reg;
        kd    = cmd.loop_pos ? pos_kd_reg : spd_kd_reg;
        ilim  = cmd.loop_pos ? PI_L : SI_L;
        case (cmd.op)
            OP_MUL_P:
            begin
                ma = kp;
                mb = e_reg;
            end
            OP_MUL_I:
            begin
                ma = ki;
                mb = e_reg;
            end
            default:
            begin
                ma = kd;
                mb = de_reg;
            end
        endcase
    end

    assign err_c  = sat32(34'(tgt) - 34'(meas));
    assign de_c   = sat32(34'(e_reg) - 34'(last));
    assign prod_c = ma * mb;
    assign i_c    = clampv(34'(integ) + 34'(qsat(prod_reg)), ilim);
    assign sum_c  = 34'(p_reg) + 34'(i_reg);
    assign o_c    = sat32(s_reg + 34'(d_reg));

    // bias pushes away from zero, zero stays zero
    assign bias34 = $signed({3'b000, dc_bias_reg});
    always_comb
    begin
        if (o_reg[31])
            o2 = 34'(o_reg) - bias34;
        else if (o_reg != 32'sd0)
            o2 = 34'(o_reg) + bias34;
        else
            o2 = '0;
    end
    assign drive_c   = clampv(o2, DUTY_L);
    assign neg_drive = -drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_kp_reg  <= '0;
            pos_ki_reg  <= '0;
            pos_kd_reg  <= '0;
            spd_kp_reg  <= '0;
            spd_ki_reg  <= '0;
            spd_kd_reg  <= '0;
            dc_bias_reg <= '0;
            scl_reg     <= 31'h7FFFFFFF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POS_KP:      pos_kp_reg  <= cfg_data;
                CFG_POS_KI:      pos_ki_reg  <= cfg_data;
                CFG_POS_KD:      pos_kd_reg  <= cfg_data;
                CFG_SPD_KP:      spd_kp_reg  <= cfg_data;
                CFG_SPD_KI:      spd_ki_reg  <= cfg_data;
                CFG_SPD_KD:      spd_kd_reg  <= cfg_data;
                CFG_DC_BIAS:     dc_bias_reg <= cfg_data[30:0];
                CFG_SPEED_LIMIT: scl_reg     <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        case (cmd.op)
            OP_ERR:   e_reg    <= err_c;
            OP_DERR:  de_reg   <= de_c;
            OP_MUL_P: prod_reg <= prod_c;
            OP_MUL_I:
            begin
                prod_reg <= prod_c;
                p_reg    <= qsat(prod_reg);
            end
            OP_MUL_D:
            begin
                prod_reg <= prod_c;
                i_reg    <= i_c;
            end
            OP_SUM:
            begin
                d_reg <= qsat(prod_reg);
                s_reg <= sum_c;
            end
            OP_WB:    o_reg     <= o_c;
            OP_BIAS:  drive_reg <= drive_c;
            OP_SET:   drive_reg <= '0;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < JOINTS; k++)
            begin
                at_reg[k] <= '0;
                pi_reg[k] <= '0;
                pl_reg[k] <= '0;
                st_reg[k] <= '0;
                si_reg[k] <= '0;
                sl_reg[k] <= '0;
            end
            engaged_reg <= ENGAGE_RESET[JOINTS-1:0];
            dir_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_WB:
                begin
                    if (cmd.loop_pos)
                    begin
                        pi_reg[jidx] <= i_reg;
                        pl_reg[jidx] <= e_reg;
                        st_reg[jidx] <= clampv(34'(o_c), {1'b0, scl_reg});
                    end
                    else
                    begin
                        si_reg[jidx] <= i_reg;
                        sl_reg[jidx] <= e_reg;
                    end
                end
                OP_BIAS:
                begin
                    if (drive_c[31])
                        dir_reg[jidx] <= 1'b0;
                    else if (drive_c != 32'sd0)
                        dir_reg[jidx] <= 1'b1;
                end
                OP_SET:
                begin
                    case (item_reg.req_type)
                        REQ_SET_ANGLE:
                        begin
                            at_reg[jidx] <= clampv(34'(item_reg.set_value), ANG_L);
                            pi_reg[jidx] <= '0;
                        end
                        REQ_SET_SPEED:
                            st_reg[jidx] <= clampv(34'(item_reg.set_value), {1'b0, scl_reg});
                        REQ_SET_ENGAGE:
                            engaged_reg[jidx] <= item_reg.set_value[0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            if (joint_ok)
            begin
                out_reg.duty_magnitude    <= drive_reg[31] ? neg_drive[30:0] : drive_reg[30:0];
                out_reg.direction_forward <= dir_reg[jidx];
                out_reg.drive_signed      <= drive_reg;
                out_reg.speed_command     <= st_reg[jidx];
            end
            else
                out_reg <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> design/cpsp_checker.sv
`include "cascaded_position_speed_pid_top_defines.svh"

module cpsp_port_props
    import cpsp_pkg::*;
#(
    parameter int DUTY_LIMIT = 6553600
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input in_item_t               in_data,
    input logic                   out_valid,
    input logic                   out_stall,
    input out_item_t              out_data,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [31:0]            cfg_data
);

    `CPSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `CPSP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    `CPSP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `CPSP_ASSERT_SAME(a_duty_limit, out_valid, {1'b0, out_data.duty_magnitude} <= 32'(DUTY_LIMIT))
    `CPSP_ASSERT_SAME(a_duty_abs, out_valid && !out_data.drive_signed[31], out_data.duty_magnitude == out_data.drive_signed[30:0])

endmodule

bind cascaded_position_speed_pid_top cpsp_port_props #(.DUTY_LIMIT(DUTY_LIMIT)) u_chk (.*);
